// ----- sv/npcm_pkg.sv -----
package npcm_pkg;

    // Request codes carried in req_type.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_MATCH = 1'b1;

    localparam logic [7:0] NO_MATCH_INDEX = 8'hFF;

    // Channel weights of the distance metric; the weighted difference is
    // shifted right arithmetically by WEIGHT_SHIFT.
    localparam logic [7:0] W_RED   = 8'd77;
    localparam logic [7:0] W_GREEN = 8'd151;
    localparam logic [7:0] W_BLUE  = 8'd28;
    localparam int         WEIGHT_SHIFT = 8;

    // Item as it travels down the chain. The pending differences belong to
    // the entry of the previous cell and are squared and compared one cell on.
    typedef struct packed {
        logic              valid;
        logic              is_match;
        logic [7:0]        entry_index;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic              last;
        logic              found;
        logic [7:0]        best_idx;
        logic [14:0]       best_dist;
        logic              pend_valid;
        logic signed [8:0] pend_dr;
        logic signed [8:0] pend_dg;
        logic signed [8:0] pend_db;
    } t_item;

    // floor((a - b) * w / 256); the result lies in -151..150.
    function automatic logic signed [8:0] scaled_diff(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] w
    );
        logic signed [8:0]  d;
        logic signed [17:0] p;
        logic signed [17:0] s;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        p = 18'(d) * $signed({10'b0, w});
        s = p >>> WEIGHT_SHIFT;
        return s[8:0];
    endfunction

    // Squares the pending differences, sums them and keeps the entry at idx
    // if it is strictly closer; a tie keeps the earlier, lower index.
    function automatic t_item finish_pending(input t_item it, input logic [7:0] idx);
        t_item              res;
        logic signed [17:0] sr;
        logic signed [17:0] sg;
        logic signed [17:0] sb;
        logic [14:0]        sum_sq;
        res = it;
        sr = 18'(it.pend_dr) * 18'(it.pend_dr);
        sg = 18'(it.pend_dg) * 18'(it.pend_dg);
        sb = 18'(it.pend_db) * 18'(it.pend_db);
        sum_sq = 15'(sr[14:0] + sg[14:0] + sb[14:0]);
        if (it.pend_valid && (!it.found || sum_sq < it.best_dist)) begin
            res.found     = 1'b1;
            res.best_idx  = idx;
            res.best_dist = sum_sq;
        end
        res.pend_valid = 1'b0;
        return res;
    endfunction

endpackage

// ----- sv/npcm_if.sv -----
interface npcm_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_colour;

    modport source (
        output valid, req_type, entry_index, red, green, blue, last_colour,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, red, green, blue, last_colour,
        output ready
    );
endinterface

interface npcm_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] best_index;
    logic       no_match;
    logic       batch_end;

    modport source (
        output valid, best_index, no_match, batch_end,
        input  ready
    );
    modport sink (
        input  valid, best_index, no_match, batch_end,
        output ready
    );
endinterface

// ----- sv/npcm_cell.sv -----
module npcm_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  logic [8:0]     i_size,
    input  npcm_pkg::t_item i_item,
    output npcm_pkg::t_item o_item
);

    localparam logic [7:0] SLOT      = 8'(CELL_IDX);
    localparam logic [7:0] PREV_SLOT = 8'(CELL_IDX - 1);
    localparam logic [8:0] SLOT_W    = 9'(CELL_IDX);

    logic [7:0]      r_red;
    logic [7:0]      r_green;
    logic [7:0]      r_blue;
    logic [7:0]      n_red;
    logic [7:0]      n_green;
    logic [7:0]      n_blue;
    npcm_pkg::t_item r_item;
    npcm_pkg::t_item n_item;

    always_comb begin
        // The previous cell's entry is settled here; this cell's entry is
        // only differenced and handed on.
        n_item  = npcm_pkg::finish_pending(i_item, PREV_SLOT);
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        if (i_item.valid && !i_item.is_match && i_item.entry_index == SLOT) begin
            n_red   = i_item.red;
            n_green = i_item.green;
            n_blue  = i_item.blue;
        end
        n_item.pend_valid = i_item.valid && i_item.is_match && (SLOT_W < i_size);
        n_item.pend_dr = npcm_pkg::scaled_diff(i_item.red, r_red, npcm_pkg::W_RED);
        n_item.pend_dg = npcm_pkg::scaled_diff(i_item.green, r_green, npcm_pkg::W_GREEN);
        n_item.pend_db = npcm_pkg::scaled_diff(i_item.blue, r_blue, npcm_pkg::W_BLUE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= '0;
            r_green <= '0;
            r_blue  <= '0;
            r_item  <= '0;
        end else if (i_advance) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_item  <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ----- sv/npcm_out.sv -----
module npcm_out #(
    parameter int LAST_IDX = 255
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  npcm_pkg::t_item i_item,
    output logic            o_advance,
    npcm_res_if.source      o_res
);

    localparam logic [7:0] LAST_SLOT = 8'(LAST_IDX);

    npcm_pkg::t_item fin;
    logic            r_valid;
    logic [7:0]      r_best;
    logic            r_no_match;
    logic            r_batch_end;

    assign o_advance = !r_valid || o_res.ready;

    always_comb begin
        fin = npcm_pkg::finish_pending(i_item, LAST_SLOT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            // Write items leave the chain here without a result.
            r_valid <= i_item.valid && i_item.is_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_best      <= fin.best_idx;
            r_no_match  <= !fin.found;
            r_batch_end <= fin.last;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.best_index = r_best;
    assign o_res.no_match   = r_no_match;
    assign o_res.batch_end  = r_batch_end;

endmodule

// ----- sv/nearest_palette_colour_match_core.sv -----
// Nearest palette colour match. Each palette entry lives in its own cell of a
// chain of PALETTE_DEPTH cells, and every item (palette write or colour match)
// walks the chain one cell per cycle while the chain advances, so one item is
// taken per cycle unless a result is stalled; a stalled result stalls the
// whole chain. Writes travel the same path, so a match sees exactly the
// writes accepted before it. The palette is zero after reset with no clearing
// pass. palette_size is saturated to PALETTE_DEPTH and should be written only
// while the chain holds no items.
module nearest_palette_colour_match_core #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_wdata,
    npcm_req_if.sink   i_req,
    npcm_res_if.source o_res
);

    localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

    logic [8:0]      r_size_q;
    logic [8:0]      n_size;
    logic            advance;
    npcm_pkg::t_item head_item;
    npcm_pkg::t_item chain [PALETTE_DEPTH + 1];

    always_comb begin
        n_size = (i_cfg_wdata > DEPTH_W) ? DEPTH_W : i_cfg_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_q <= '0;
        end else if (i_cfg_we) begin
            r_size_q <= n_size;
        end
    end

    assign i_req.ready = advance;

    always_comb begin
        head_item             = '0;
        head_item.valid       = i_req.valid;
        head_item.is_match    = (i_req.req_type == npcm_pkg::REQ_MATCH);
        head_item.entry_index = i_req.entry_index;
        head_item.red         = i_req.red;
        head_item.green       = i_req.green;
        head_item.blue        = i_req.blue;
        head_item.last        = i_req.last_colour;
        head_item.best_idx    = npcm_pkg::NO_MATCH_INDEX;
    end

    assign chain[0] = head_item;

    for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
        npcm_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_size    (r_size_q),
            .i_item    (chain[k]),
            .o_item    (chain[k + 1])
        );
    end

    npcm_out #(
        .LAST_IDX (PALETTE_DEPTH - 1)
    ) u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (chain[PALETTE_DEPTH]),
        .o_advance (advance),
        .o_res     (o_res)
    );

`ifndef SYNTHESIS
    a_size_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size_q <= DEPTH_W)
        else $error("palette size register out of range");

    a_no_match_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.no_match |-> o_res.best_index == npcm_pkg::NO_MATCH_INDEX)
        else $error("no_match result without the no-match index");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.no_match |-> {1'b0, o_res.best_index} < DEPTH_W)
        else $error("best index beyond the palette depth");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result item right after reset");
`endif

endmodule

// ----- verif/tb.sv -----
module tb;

    localparam int DEPTH        = 256;
    localparam int PIPE_LATENCY = DEPTH + 1;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [7:0] best_index;
        logic       no_match;
        logic       batch_end;
    } t_match_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [8:0] i_cfg_wdata = '0;

    npcm_req_if req_if ();
    npcm_res_if res_if ();

    nearest_palette_colour_match_core #(
        .PALETTE_DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    always #2 i_clk = ~i_clk;

    // Local copy of the palette and the size register.
    logic [7:0]    pal_red   [DEPTH];
    logic [7:0]    pal_green [DEPTH];
    logic [7:0]    pal_blue  [DEPTH];
    logic [8:0]    palette_size_q = '0;
    t_match_result pending_matches[$];

    int mismatches  = 0;
    int cycle_count = 0;
    int burst_left  = 0;

    initial begin
        req_if.valid       = 1'b0;
        req_if.req_type    = npcm_pkg::REQ_WRITE;
        req_if.entry_index = '0;
        req_if.red         = '0;
        req_if.green       = '0;
        req_if.blue        = '0;
        req_if.last_colour = 1'b0;
        res_if.ready       = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            pal_red[k]   = '0;
            pal_green[k] = '0;
            pal_blue[k]  = '0;
        end
    end

    function automatic int active_entries();
        return (palette_size_q > DEPTH) ? DEPTH : int'(palette_size_q);
    endfunction

    function automatic int scaled_channel(input logic [7:0] src, input logic [7:0] ent,
                                          input logic [7:0] weight);
        int prod;
        prod = (int'(src) - int'(ent)) * int'(weight);
        return prod >>> npcm_pkg::WEIGHT_SHIFT;
    endfunction

    function automatic t_match_result nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                                    input logic [7:0] b, input logic last);
        t_match_result res;
        int            span;
        int            dr;
        int            dg;
        int            db;
        int            sum_sq;
        int            best_dist;
        span           = active_entries();
        res.best_index = npcm_pkg::NO_MATCH_INDEX;
        res.no_match   = 1'b1;
        res.batch_end  = last;
        best_dist      = 0;
        for (int t = 0; t < span; t++) begin
            dr     = scaled_channel(r, pal_red[t], npcm_pkg::W_RED);
            dg     = scaled_channel(g, pal_green[t], npcm_pkg::W_GREEN);
            db     = scaled_channel(b, pal_blue[t], npcm_pkg::W_BLUE);
            sum_sq = dr * dr + dg * dg + db * db;
            if (res.no_match || sum_sq < best_dist) begin
                res.no_match   = 1'b0;
                res.best_index = 8'(t);
                best_dist      = sum_sq;
            end
        end
        return res;
    endfunction

    // Sends one item, opening a new burst after a random gap when the current one is used up.
    task automatic send_item(input logic req, input logic [7:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                req_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_if.valid       = 1'b1;
        req_if.req_type    = req;
        req_if.entry_index = idx;
        req_if.red         = r;
        req_if.green       = g;
        req_if.blue        = b;
        req_if.last_colour = last;
        do @(posedge i_clk); while (!req_if.ready);
        if (req == npcm_pkg::REQ_WRITE) begin
            pal_red[idx]   = r;
            pal_green[idx] = g;
            pal_blue[idx]  = b;
        end else begin
            pending_matches.push_back(nearest_entry(r, g, b, last));
        end
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        req_if.valid = 1'b0;
        while (pending_matches.size() != 0) @(negedge i_clk);
    endtask

    // Writes may still be in the chain after the last result, so let it empty first.
    task automatic program_palette_size(input logic [8:0] size);
        wait_for_drain();
        repeat (PIPE_LATENCY + 4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = size;
        @(negedge i_clk);
        i_cfg_we       = 1'b0;
        palette_size_q = size;
    endtask

    function automatic logic [7:0] near_channel(input logic [7:0] c);
        int v;
        v = int'(c) + $urandom_range(0, 8) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    task automatic send_random_item();
        int         kind;
        int         span;
        int         slot;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        span = active_entries();
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else if (span > 0 && kind < 55) begin
            slot = $urandom_range(0, span - 1);
            r    = near_channel(pal_red[slot]);
            g    = near_channel(pal_green[slot]);
            b    = near_channel(pal_blue[slot]);
        end else begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
        end
        if ($urandom_range(0, 99) < 30) begin
            slot = (span > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, span - 1)
                                                           : $urandom_range(0, 255);
            send_item(npcm_pkg::REQ_WRITE, 8'(slot), r, g, b, 1'($urandom_range(0, 1)));
        end else begin
            send_item(npcm_pkg::REQ_MATCH, 8'($urandom), r, g, b, $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic test_empty_palette();
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        send_item(npcm_pkg::REQ_MATCH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        // The cleared palette makes every entry tie, so index zero wins.
        program_palette_size(9'd256);
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_zero_distance_and_ties();
        send_item(npcm_pkg::REQ_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_item(npcm_pkg::REQ_WRITE, 8'd128, 8'hFF, 8'h00, 8'h00, 1'b1);
        send_item(npcm_pkg::REQ_WRITE, 8'd1, 8'h00, 8'hFF, 8'h00, 1'b0);
        send_item(npcm_pkg::REQ_WRITE, 8'd2, 8'h00, 8'h00, 8'hFF, 1'b0);
        send_item(npcm_pkg::REQ_WRITE, 8'd3, 8'h80, 8'h80, 8'h80, 1'b0);
        send_item(npcm_pkg::REQ_WRITE, 8'd4, 8'h01, 8'h00, 8'h00, 1'b0);
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0);
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0);
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'h80, 8'h80, 8'h80, 1'b0);
        // Small differences round toward minus infinity, so only a positive one scales to zero.
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'h01, 8'h01, 8'h01, 1'b0);
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    endtask

    task automatic test_size_saturation();
        program_palette_size(9'd511);
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'hFE, 8'h01, 8'h02, 1'b1);
        program_palette_size(9'd1);
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        program_palette_size(9'd4);
        send_item(npcm_pkg::REQ_MATCH, 8'h00, 8'h00, 8'h00, 8'hF0, 1'b1);
    endtask

    task automatic test_random_phases();
        int sizes[12] = '{1, 2, 3, 8, 16, 64, 256, 511, 0, 300, -1, -1};
        int span;
        for (int p = 0; p < 12; p++) begin
            program_palette_size((sizes[p] < 0) ? 9'($urandom_range(0, 511)) : 9'(sizes[p]));
            span = active_entries();
            for (int k = 0; k < ((span < 16) ? span : 16); k++) begin
                send_item(npcm_pkg::REQ_WRITE, 8'(k), 8'($urandom), 8'($urandom),
                          8'($urandom), 1'b0);
            end
            repeat (130) send_random_item();
        end
    endtask

    task automatic test_drain_and_resume();
        program_palette_size(9'd32);
        repeat (40) send_random_item();
        wait_for_drain();
        repeat (40) send_random_item();
    endtask

    // The receiver changes its stall rate every so often, including stretches with no stalls.
    int stall_pct  = 0;
    int stall_hold = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (stall_hold == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                stall_hold = $urandom_range(32, 256);
            end
            stall_hold--;
            res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_match_result exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: idx %0d no_match %0b end %0b",
                             res_if.best_index, res_if.no_match, res_if.batch_end);
                end
            end else begin
                exp_res = pending_matches.pop_front();
                if (res_if.best_index !== exp_res.best_index ||
                    res_if.no_match !== exp_res.no_match ||
                    res_if.batch_end !== exp_res.batch_end) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"mismatch: expected idx %0d no_match %0b end %0b, ",
                                  "got idx %0d no_match %0b end %0b"},
                                 exp_res.best_index, exp_res.no_match, exp_res.batch_end,
                                 res_if.best_index, res_if.no_match, res_if.batch_end);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_empty_palette();
        test_zero_distance_and_ties();
        test_size_saturation();
        test_random_phases();
        test_drain_and_resume();
        wait_for_drain();
        repeat (PIPE_LATENCY + 16) @(negedge i_clk);
        if (mismatches == 0 && pending_matches.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
